### sv/extent_map_insert_coalesce_unit_macros.svh
// ----------------------------------------------------------------------------
// Extent map insert unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXTENT_MAP_INSERT_COALESCE_UNIT_MACROS_SVH
`define EXTENT_MAP_INSERT_COALESCE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EMIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/emic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map insert unit package
// Default sizes, request and result codes, sequencer states and the
// verdict that the gap comparator hands to the sequencer.
// ----------------------------------------------------------------------------
package emic_pkg;

  localparam int EMIC_MAX_EXTENTS = 64;
  localparam int EMIC_BLOCK_BITS  = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_INIT   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_GAP  = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PL_MERGED = 3'd0,
    PL_LEFT   = 3'd1,
    PL_RIGHT  = 3'd2,
    PL_MIDDLE = 3'd3,
    PL_NONE   = 3'd4
  } placement_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_EVAL,
    S_MRG_RD,
    S_MRG_WR,
    S_DROP_RD,
    S_DROP_WR,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_FREE,
    S_EMIT
  } emic_state_t;

  // Classification of the range against one extent and the gap after it.
  typedef struct packed {
    logic merge_both;
    logic left_ext;
    logic right_ext;
    logic middle;
  } gap_verdict_t;

endpackage

### sv/emic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map request channel
// Valid/ready channel carrying one insert or init request.
// ----------------------------------------------------------------------------
interface emic_in_if #(
  parameter int BLOCK_BITS = emic_pkg::EMIC_BLOCK_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [BLOCK_BITS-1:0] range_low;
  logic [BLOCK_BITS-1:0] range_high;

  modport source (output valid, output req_type, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input req_type, input range_low, input range_high,
                  output ready);
endinterface

### sv/emic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface emic_out_if #(
  parameter int BLOCK_BITS = emic_pkg::EMIC_BLOCK_BITS,
  parameter int CNT_W      = $clog2(emic_pkg::EMIC_MAX_EXTENTS + 1)
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [2:0]          placement;
  logic [CNT_W-1:0]    extent_count;
  logic [BLOCK_BITS:0] free_blocks;

  modport source (output valid, output status, output placement, output extent_count,
                  output free_blocks, input ready);
  modport sink   (input valid, input status, input placement, input extent_count,
                  input free_blocks, output ready);
endinterface

### sv/extent_map_insert_coalesce_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map insert unit with coalescing
// Keeps a sorted table of used block extents and a free block counter.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (insert a used range, or reinitialize the table to
// one reserved extent); each request gives exactly one result on out_ch with
// status, placement, extent count and free block count. The end bound of the
// block space is written through cfg_we/cfg_wdata; the user must do so only
// while the unit is idle, since the unit does not enforce it. The unit
// handles one request at a time and drops in_ch.ready while busy. A scan
// visits each extent in a read state and an evaluate state, and moving an
// entry when the table opens or closes a slot takes a read state and a
// write state, since each extent memory has one read and one write port.
// A new entry is placed in S_INS_PUT; a merge with the next extent reads
// and writes its high end in S_MRG_RD and S_MRG_WR.
// The result sits in an output register, so the next request may transfer
// while the previous result still waits for out_ch.ready; the unit only
// stalls before loading a new result into a register that is still full.
// Reset empties the table, clears the free counter and sets the end bound to
// 2^BLOCK_BITS; no clearing pass runs over the memories.
// ----------------------------------------------------------------------------
module extent_map_insert_coalesce_unit #(
  parameter int MAX_EXTENTS = emic_pkg::EMIC_MAX_EXTENTS,
  parameter int BLOCK_BITS  = emic_pkg::EMIC_BLOCK_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  emic_in_if.sink             in_ch,
  emic_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [BLOCK_BITS:0] cfg_wdata
);
  import emic_pkg::*;

  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

  emic_state_t           state_r, state_nxt;
  logic [BLOCK_BITS-1:0] lo_r, lo_nxt;
  logic [BLOCK_BITS-1:0] hi_r, hi_nxt;
  logic [BLOCK_BITS:0]   size_r, size_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BLOCK_BITS:0]   free_r, free_nxt;
  logic [BLOCK_BITS:0]   bend_r, bend_nxt;
  status_t               st_r, st_nxt;
  placement_t            pl_r, pl_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_st_r, out_st_nxt;
  placement_t            out_pl_r, out_pl_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [BLOCK_BITS:0]   out_free_r, out_free_nxt;

  logic                  lo_we, hi_we;
  logic [IDX_W-1:0]      lo_waddr, hi_waddr, lo_raddr, hi_raddr;
  logic [BLOCK_BITS-1:0] lo_wdata, hi_wdata, lo_rdata, hi_rdata;

  logic                  in_xfer;
  logic                  out_free_slot;
  logic [CNT_W-1:0]      idx_p1, ptr_p1, cnt_m1;
  logic                  has_next;
  logic                  tbl_full;
  logic [BLOCK_BITS:0]   init_free;
  gap_verdict_t          verdict;

  emic_ram #(.DEPTH(MAX_EXTENTS), .WIDTH(BLOCK_BITS)) u_low_ram (
    .clk     (clk),
    .wr_en   (lo_we),
    .wr_addr (lo_waddr),
    .wr_data (lo_wdata),
    .rd_addr (lo_raddr),
    .rd_data (lo_rdata)
  );

  emic_ram #(.DEPTH(MAX_EXTENTS), .WIDTH(BLOCK_BITS)) u_high_ram (
    .clk     (clk),
    .wr_en   (hi_we),
    .wr_addr (hi_waddr),
    .wr_data (hi_wdata),
    .rd_addr (hi_raddr),
    .rd_data (hi_rdata)
  );

  emic_gap_cmp #(.BLOCK_BITS(BLOCK_BITS)) u_gap_cmp (
    .range_low  (lo_r),
    .range_high (hi_r),
    .cur_high   (hi_rdata),
    .next_low   (lo_rdata),
    .has_next   (has_next),
    .end_limit  (bend_r),
    .verdict    (verdict)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_free_slot = !out_valid_r || out_ch.ready;
  assign idx_p1        = CNT_W'(idx_r) + CNT_W'(1);
  assign ptr_p1        = CNT_W'(ptr_r) + CNT_W'(1);
  assign cnt_m1        = cnt_r - CNT_W'(1);
  assign has_next      = idx_p1 < cnt_r;
  assign tbl_full      = cnt_r >= CNT_W'(MAX_EXTENTS);
  assign init_free     = (bend_r > {1'b0, hi_r}) ?
                         (bend_r - {1'b0, hi_r} - (BLOCK_BITS+1)'(1)) : '0;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.placement    = out_pl_r;
  assign out_ch.extent_count = out_cnt_r;
  assign out_ch.free_blocks  = out_free_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.req_type == REQ_INIT) begin
            state_nxt = S_INIT;
          end else if ((in_ch.range_low > in_ch.range_high) || (cnt_r == '0)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_INIT:   state_nxt = S_EMIT;
      S_RD:     state_nxt = S_EVAL;
      S_EVAL: begin
        if (verdict.merge_both) begin
          state_nxt = has_next ? S_MRG_RD : S_FREE;
        end else if (verdict.left_ext) begin
          state_nxt = S_FREE;
        end else if (verdict.right_ext) begin
          if (has_next) begin
            state_nxt = S_FREE;
          end else begin
            state_nxt = tbl_full ? S_EMIT : S_INS_PUT;
          end
        end else if (verdict.middle) begin
          if (tbl_full) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = has_next ? S_INS_RD : S_INS_PUT;
          end
        end else begin
          state_nxt = has_next ? S_RD : S_EMIT;
        end
      end
      S_MRG_RD:  state_nxt = S_MRG_WR;
      S_MRG_WR:  state_nxt = (idx_p1 < cnt_m1) ? S_DROP_RD : S_FREE;
      S_DROP_RD: state_nxt = S_DROP_WR;
      S_DROP_WR: state_nxt = (ptr_p1 < cnt_m1) ? S_DROP_RD : S_FREE;
      S_INS_RD:  state_nxt = S_INS_WR;
      S_INS_WR:  state_nxt = (CNT_W'(ptr_r) > idx_p1) ? S_INS_RD : S_INS_PUT;
      S_INS_PUT: state_nxt = S_FREE;
      S_FREE:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free_slot) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory ports and datapath register updates.
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    free_nxt      = free_r;
    bend_nxt      = cfg_we ? cfg_wdata : bend_r;
    st_nxt        = st_r;
    pl_nxt        = pl_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_pl_nxt    = out_pl_r;
    out_cnt_nxt   = out_cnt_r;
    out_free_nxt  = out_free_r;

    lo_we    = 1'b0;
    hi_we    = 1'b0;
    lo_waddr = idx_r;
    hi_waddr = idx_r;
    lo_wdata = lo_r;
    hi_wdata = hi_r;
    lo_raddr = IDX_W'(idx_p1);
    hi_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          lo_nxt   = in_ch.range_low;
          hi_nxt   = in_ch.range_high;
          size_nxt = ({1'b0, in_ch.range_high} - {1'b0, in_ch.range_low})
                     + (BLOCK_BITS+1)'(1);
          idx_nxt  = '0;
          st_nxt   = ST_NO_GAP;
          pl_nxt   = PL_NONE;
        end
      end
      S_INIT: begin
        lo_we    = 1'b1;
        lo_waddr = '0;
        lo_wdata = '0;
        hi_we    = 1'b1;
        hi_waddr = '0;
        hi_wdata = hi_r;
        cnt_nxt  = CNT_W'(1);
        free_nxt = init_free;
        st_nxt   = ST_OK;
      end
      S_RD: begin
        // Default read addresses fetch this extent's high and the next low.
      end
      S_EVAL: begin
        ptr_nxt = IDX_W'(cnt_m1);
        if (verdict.merge_both) begin
          pl_nxt = PL_MERGED;
          if (!has_next) begin
            hi_we = 1'b1;
          end
        end else if (verdict.left_ext) begin
          pl_nxt = PL_LEFT;
          hi_we  = 1'b1;
        end else if (verdict.right_ext) begin
          if (has_next) begin
            pl_nxt   = PL_RIGHT;
            lo_we    = 1'b1;
            lo_waddr = IDX_W'(idx_p1);
          end else if (tbl_full) begin
            st_nxt = ST_FULL;
          end else begin
            pl_nxt = PL_RIGHT;
          end
        end else if (verdict.middle) begin
          if (tbl_full) begin
            st_nxt = ST_FULL;
          end else begin
            pl_nxt = PL_MIDDLE;
          end
        end else if (has_next) begin
          idx_nxt = IDX_W'(idx_p1);
        end
      end
      S_MRG_RD: begin
        hi_raddr = IDX_W'(idx_p1);
      end
      S_MRG_WR: begin
        // The left extent absorbs the right one; later entries then slide down.
        hi_we    = 1'b1;
        hi_wdata = hi_rdata;
        ptr_nxt  = IDX_W'(idx_p1);
        if (!(idx_p1 < cnt_m1)) begin
          cnt_nxt = cnt_m1;
        end
      end
      S_DROP_RD: begin
        lo_raddr = IDX_W'(ptr_p1);
        hi_raddr = IDX_W'(ptr_p1);
      end
      S_DROP_WR: begin
        lo_we    = 1'b1;
        hi_we    = 1'b1;
        lo_waddr = ptr_r;
        hi_waddr = ptr_r;
        lo_wdata = lo_rdata;
        hi_wdata = hi_rdata;
        ptr_nxt  = IDX_W'(ptr_p1);
        if (!(ptr_p1 < cnt_m1)) begin
          cnt_nxt = cnt_m1;
        end
      end
      S_INS_RD: begin
        lo_raddr = ptr_r;
        hi_raddr = ptr_r;
      end
      S_INS_WR: begin
        // Entries move up one slot, from the top of the table down.
        lo_we    = 1'b1;
        hi_we    = 1'b1;
        lo_waddr = IDX_W'(ptr_p1);
        hi_waddr = IDX_W'(ptr_p1);
        lo_wdata = lo_rdata;
        hi_wdata = hi_rdata;
        ptr_nxt  = ptr_r - IDX_W'(1);
      end
      S_INS_PUT: begin
        lo_we    = 1'b1;
        hi_we    = 1'b1;
        lo_waddr = IDX_W'(idx_p1);
        hi_waddr = IDX_W'(idx_p1);
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      S_FREE: begin
        free_nxt = (free_r > size_r) ? (free_r - size_r) : '0;
        st_nxt   = ST_OK;
      end
      S_EMIT: begin
        if (out_free_slot) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_pl_nxt    = pl_r;
          out_cnt_nxt   = cnt_r;
          out_free_nxt  = free_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      free_r      <= '0;
      bend_r      <= {1'b1, {BLOCK_BITS{1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      free_r      <= free_nxt;
      bend_r      <= bend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    size_r     <= size_nxt;
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    st_r       <= st_nxt;
    pl_r       <= pl_nxt;
    out_st_r   <= out_st_nxt;
    out_pl_r   <= out_pl_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_free_r <= out_free_nxt;
  end

`include "extent_map_insert_coalesce_unit_macros.svh"

  `EMIC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_EXTENTS), "extent count above table size")
  `EMIC_ASSERT_SAME(a_ins_ptr_range, (state_r == S_INS_RD) || (state_r == S_INS_WR), (CNT_W'(ptr_r) < cnt_r) && !tbl_full, "insert shift pointer out of range")
  `EMIC_ASSERT_SAME(a_drop_ptr_range, (state_r == S_DROP_RD) || (state_r == S_DROP_WR), ptr_p1 < cnt_r, "removal shift pointer out of range")
  `EMIC_ASSERT_NEXT(a_free_no_rise, rst_n && (state_r != S_INIT), free_r <= $past(free_r), "free counter rose outside init")

endmodule

### sv/emic_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module emic_ram #(
  parameter int DEPTH = emic_pkg::EMIC_MAX_EXTENTS,
  parameter int WIDTH = emic_pkg::EMIC_BLOCK_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

### sv/emic_gap_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map gap comparator
// Compares the pending range with one extent and the gap that follows it,
// and classifies how the range would be placed there.
// ----------------------------------------------------------------------------
module emic_gap_cmp #(
  parameter int BLOCK_BITS = emic_pkg::EMIC_BLOCK_BITS
) (
  input  logic [BLOCK_BITS-1:0]  range_low,
  input  logic [BLOCK_BITS-1:0]  range_high,
  input  logic [BLOCK_BITS-1:0]  cur_high,
  input  logic [BLOCK_BITS-1:0]  next_low,
  input  logic                   has_next,
  input  logic [BLOCK_BITS:0]    end_limit,
  output emic_pkg::gap_verdict_t verdict
);
  import emic_pkg::*;

  logic [BLOCK_BITS:0] gap_end;
  logic [BLOCK_BITS:0] after;
  logic [BLOCK_BITS:0] lo_x;
  logic [BLOCK_BITS:0] hi_x;
  logic                fits;
  logic                lo_eq;
  logic                lo_gt;
  logic                hi_end;

  assign gap_end = has_next ? {1'b0, next_low} : end_limit;
  assign after   = {1'b0, cur_high} + (BLOCK_BITS+1)'(1);
  assign lo_x    = {1'b0, range_low};
  assign hi_x    = {1'b0, range_high};

  // When the range fits, gap_end is at least one, so the decrement is safe.
  assign fits   = hi_x < gap_end;
  assign lo_eq  = lo_x == after;
  assign lo_gt  = lo_x > after;
  assign hi_end = hi_x == (gap_end - (BLOCK_BITS+1)'(1));

  always_comb begin
    verdict = '0;
    if (fits) begin
      if (lo_eq && hi_end) begin
        verdict.merge_both = 1'b1;
      end else if (lo_eq) begin
        verdict.left_ext = 1'b1;
      end else if (lo_gt && hi_end) begin
        verdict.right_ext = 1'b1;
      end else if (lo_gt) begin
        verdict.middle = 1'b1;
      end
    end
  end
endmodule

### bench/extent_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map insert unit checker
// Watches the request, result and end bound configuration ports, keeps its
// own copy of the extent table and free counter, and compares every result
// transfer with the outcome predicted when its request was accepted.
// ----------------------------------------------------------------------------
module extent_map_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  emic_in_if                                in_ch,
  emic_out_if                               out_ch,
  input  logic                              cfg_we,
  input  logic [emic_pkg::EMIC_BLOCK_BITS:0] cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import emic_pkg::*;

  localparam int BB    = EMIC_BLOCK_BITS;
  localparam int DEPTH = EMIC_MAX_EXTENTS;

  typedef struct packed {
    status_t     status;
    placement_t  placement;
    logic [6:0]  count;
    logic [BB:0] free;
  } extent_outcome_t;

  logic [BB-1:0]   ext_lo [DEPTH];
  logic [BB-1:0]   ext_hi [DEPTH];
  int unsigned     ext_count;
  logic [BB:0]     free_left;
  logic [BB:0]     span_end;
  extent_outcome_t outcomes_due [$];

  // Shifts the tail up by one entry and places [lo, hi] at pos.
  function automatic void open_slot(input int unsigned pos, input logic [BB-1:0] lo,
                                    input logic [BB-1:0] hi);
    for (int unsigned j = ext_count; j > pos; j--) begin
      ext_lo[j] = ext_lo[j-1];
      ext_hi[j] = ext_hi[j-1];
    end
    ext_lo[pos] = lo;
    ext_hi[pos] = hi;
    ext_count++;
  endfunction

  function automatic extent_outcome_t place_request(input logic kind,
                                                    input logic [BB-1:0] lo32,
                                                    input logic [BB-1:0] hi32);
    extent_outcome_t res;
    logic [BB:0]     lo, hi, bound, gap_start, span;
    logic            has_next, stop;
    placement_t      where;
    lo = {1'b0, lo32};
    hi = {1'b0, hi32};
    where = PL_NONE;
    stop = 1'b0;
    res.status = ST_OK;
    if (kind == REQ_INIT) begin
      ext_count = 1;
      ext_lo[0] = '0;
      ext_hi[0] = hi32;
      free_left = (span_end > hi) ? span_end - hi - 1'b1 : '0;
    end else if (lo > hi) begin
      res.status = ST_NO_GAP;
    end else begin
      for (int unsigned i = 0; i < ext_count && !stop; i++) begin
        has_next = (i + 1 < ext_count);
        bound = has_next ? {1'b0, ext_lo[i+1]} : span_end;
        gap_start = {1'b0, ext_hi[i]} + 1'b1;
        // A range reaching the next extent or the end bound cannot go in this gap.
        if (hi < bound) begin
          stop = 1'b1;
          if (lo == gap_start && hi == bound - 1'b1) begin
            where = PL_MERGED;
            if (has_next) begin
              ext_hi[i] = ext_hi[i+1];
              for (int unsigned j = i + 1; j + 1 < ext_count; j++) begin
                ext_lo[j] = ext_lo[j+1];
                ext_hi[j] = ext_hi[j+1];
              end
              ext_count--;
            end else begin
              ext_hi[i] = hi32;
            end
          end else if (lo == gap_start) begin
            where = PL_LEFT;
            ext_hi[i] = hi32;
          end else if (lo > gap_start && hi == bound - 1'b1 && has_next) begin
            where = PL_RIGHT;
            ext_lo[i+1] = lo32;
          end else if (lo > gap_start && ext_count < DEPTH) begin
            where = (hi == bound - 1'b1) ? PL_RIGHT : PL_MIDDLE;
            open_slot(i + 1, lo32, hi32);
          end else if (lo > gap_start) begin
            // Needs a new entry but the table is full; the scan stops here.
            res.status = ST_FULL;
          end else begin
            // The range starts at or before this extent's end, so try the following gap.
            stop = 1'b0;
          end
        end
      end
      if (!stop) begin
        res.status = ST_NO_GAP;
      end else if (res.status == ST_OK) begin
        span = hi - lo + 1'b1;
        free_left = (free_left > span) ? free_left - span : '0;
      end
    end
    res.placement = where;
    res.count = 7'(ext_count);
    res.free = free_left;
    return res;
  endfunction

  // The result side is handled before the request side, so a result never
  // pairs with a request that transfers on the same edge.
  always @(posedge clk) begin
    extent_outcome_t want, got;
    if (!rst_n) begin
      ext_count = 0;
      free_left = '0;
      span_end = {1'b1, {BB{1'b0}}};
      outcomes_due.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.placement = placement_t'(out_ch.placement);
        got.count = out_ch.extent_count;
        got.free = out_ch.free_blocks;
        if (outcomes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result transfer with no request outstanding", $time);
          end
        end else begin
          want = outcomes_due.pop_front();
          if (got.status !== want.status || got.placement !== want.placement ||
              got.count !== want.count || got.free !== want.free) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: expected status %0d placement %0d count %0d free %0d",
                       $time, want.status, want.placement, want.count, want.free);
              $display("%0t:           got status %0d placement %0d count %0d free %0d",
                       $time, got.status, got.placement, got.count, got.free);
            end
          end
        end
      end
      if (cfg_we) begin
        span_end = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        outcomes_due.push_back(place_request(in_ch.req_type, in_ch.range_low,
                                             in_ch.range_high));
      end
    end
    pending = outcomes_due.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent map insert unit testbench
// Runs a directed pass over every placement and the no-gap errors, then
// random episodes of init followed by inserts aimed at the gaps of the
// current table, under changing end bounds and sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import emic_pkg::*;

  localparam int BB = EMIC_BLOCK_BITS;
  // About 1050 items in all, directed ones included.
  localparam int LAST_ITEM = 1050;
  localparam logic [BB:0] FULL_SPAN = {1'b1, {BB{1'b0}}};

  typedef enum int {SHAPE_FILL, SHAPE_LEFT, SHAPE_RIGHT, SHAPE_MIDDLE} shape_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [BB:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;

  emic_in_if  in_ch ();
  emic_out_if out_ch ();

  extent_map_insert_coalesce_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  extent_map_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [BB-1:0] lo, input logic [BB-1:0] hi);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.range_low  <= lo;
    in_ch.range_high <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // The end bound only changes once every outstanding result has come back.
  task automatic write_end_limit(input logic [BB:0] value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_noise(input logic allow_init);
    logic [BB-1:0] lo, hi;
    int unsigned   k, pick;
    lo = $urandom;
    hi = $urandom;
    pick = $urandom_range(9);
    case (pick)
      4, 5: hi = lo - 1'b1 - $urandom_range(15);
      6: begin
        if (chk.ext_count > 0) begin
          k = $urandom_range(chk.ext_count - 1);
          lo = chk.ext_lo[k] + $urandom_range(3);
          hi = lo + $urandom_range(15);
        end
      end
      8: hi = lo + $urandom_range(15);
      9: begin
        hi = '1;
        lo = hi - $urandom_range(15);
      end
      default: ;
    endcase
    if (pick == 7 && allow_init) begin
      send_item(REQ_INIT, lo, hi);
    end else begin
      send_item(REQ_INSERT, lo, hi);
    end
  endtask

  // Picks one gap of the current table and aims a range of the given shape
  // at it; an empty gap turns into a random request instead.
  task automatic send_into_gap(input shape_t shape, input logic allow_init);
    longint unsigned g_lo, bound, size, lim, len, lo, hi;
    int unsigned     k;
    k = $urandom_range(chk.ext_count - 1);
    g_lo = 64'(chk.ext_hi[k]);
    g_lo++;
    bound = (k + 1 < chk.ext_count) ? 64'(chk.ext_lo[k+1]) : 64'(chk.span_end);
    if (bound <= g_lo) begin
      send_noise(allow_init);
    end else begin
      size = bound - g_lo;
      if (shape == SHAPE_MIDDLE && size < 3) shape = SHAPE_LEFT;
      lim = (shape == SHAPE_MIDDLE) ? size - 2 : size;
      len = ($urandom_range(3) == 0) ? 1 + $urandom % lim : 1 + $urandom_range(7) % lim;
      case (shape)
        SHAPE_FILL: begin
          lo = g_lo;
          hi = bound - 1;
        end
        SHAPE_LEFT: begin
          lo = g_lo;
          hi = g_lo + len - 1;
        end
        SHAPE_RIGHT: begin
          hi = bound - 1;
          lo = bound - len;
        end
        default: begin
          lo = g_lo + 1 + $urandom % (size - 1 - len);
          hi = lo + len - 1;
        end
      endcase
      send_item(REQ_INSERT, lo[BB-1:0], hi[BB-1:0]);
    end
  endtask

  initial begin
    int unsigned   phase, body, r;
    logic          frag;
    logic [BB-1:0] init_hi;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_INSERT;
    in_ch.range_low  = '0;
    in_ch.range_high = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass with the end bound at its reset value of 2^32.
    send_item(REQ_INSERT, 32'd5, 32'd10);          // empty table
    send_item(REQ_INIT, 32'd0, 32'd9);
    send_item(REQ_INSERT, 32'd10, 32'd19);         // extends the left extent
    send_item(REQ_INSERT, 32'd30, 32'd39);         // new entry in the middle
    send_item(REQ_INSERT, 32'd25, 32'd29);         // extends the right extent
    send_item(REQ_INSERT, 32'd20, 32'd24);         // fills the gap, merges both
    send_item(REQ_INSERT, 32'd20, 32'd30);         // overlaps an extent
    send_item(REQ_INSERT, 32'd50, 32'd40);         // reversed range
    send_item(REQ_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(REQ_INSERT, 32'd40, 32'hFFFF_FFEF);
    send_item(REQ_INIT, 32'd0, 32'd0);
    send_item(REQ_INSERT, 32'd1, 32'hFFFF_FFFF);   // fills up to the end bound
    send_item(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_end_limit(33'd1);
    send_item(REQ_INIT, 32'd0, 32'd0);
    send_item(REQ_INSERT, 32'd1, 32'd1);
    send_item(REQ_INIT, 32'd0, 32'd5);             // reserved end past the end bound
    write_end_limit(33'd100);
    send_item(REQ_INIT, 32'd0, 32'd49);
    send_item(REQ_INSERT, 32'd90, 32'd99);
    write_end_limit(FULL_SPAN);
    send_item(REQ_INSERT, 32'd120, 32'd300);       // free counter saturates
    send_item(REQ_INSERT, 32'd0, 32'd0);

    // Random episodes. The first one always fragments the table until it is
    // full, so that the table-full error is reached.
    phase = 0;
    while (items_sent < LAST_ITEM) begin
      case (phase % 5)
        1: begin
          sender_idle_pct = 49;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 49;
        end
        3: begin
          sender_idle_pct = 11;
          stall_pct = 11;
        end
        default: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      frag = (phase == 0) || ($urandom_range(3) == 0);
      if (frag) begin
        write_end_limit(33'd1000 + $urandom_range(9000));
      end else if ($urandom_range(1) == 0) begin
        r = $urandom_range(5);
        case (r)
          0: write_end_limit(FULL_SPAN);
          1: write_end_limit(33'd1 + $urandom_range(15));
          2: write_end_limit({1'b0, $urandom} + 1'b1);
          default: write_end_limit(33'd64 + $urandom_range(5000));
        endcase
      end
      r = $urandom_range(9);
      if (frag || r < 7) begin
        init_hi = (chk.span_end > 64) ? $urandom_range(63) : $urandom_range(32'(chk.span_end - 1));
      end else if (r < 9) begin
        init_hi = 32'($urandom % chk.span_end);
      end else begin
        init_hi = $urandom;
      end
      send_item(REQ_INIT, $urandom, init_hi);
      body = frag ? 110 + $urandom_range(40) : 20 + $urandom_range(60);
      for (int unsigned n = 0; n < body && items_sent < LAST_ITEM; n++) begin
        if ($urandom_range(99) < 85 && chk.ext_count > 0) begin
          if (frag && chk.ext_count < EMIC_MAX_EXTENTS && $urandom_range(7) != 0) begin
            send_into_gap(SHAPE_MIDDLE, !frag);
          end else begin
            send_into_gap(shape_t'($urandom_range(3)), !frag);
          end
        end else begin
          send_noise(!frag);
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/emic_pkg.sv
sv/emic_in_if.sv
sv/emic_out_if.sv
sv/emic_ram.sv
sv/emic_gap_cmp.sv
sv/extent_map_insert_coalesce_unit.sv
bench/extent_map_checker.sv
bench/tb.sv
